// File: design/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int PRIO_LEVELS = 32;
   localparam int VM_SLOTS    = 16;
   localparam int LVL_W       = $clog2(PRIO_LEVELS);
   localparam int VM_W        = $clog2(VM_SLOTS);
   localparam int QDEPTH      = 2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_SPARE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_DUP_INSERT = 2'd1,
      ST_NOT_QUEUED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      cmd_type           cmd;
      logic [VM_W-1:0]   vm;
      logic [LVL_W-1:0]  lvl;
   } work_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_READ  = 2'd1,
      BK_WRITE = 2'd2,
      BK_OUT   = 2'd3
   } back_state_type;

endpackage

// File: design/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_ready_queue
// Bitmap-indexed run queue with one FIFO of VM slots per priority level.
// ----------------------------------------------------------------------------
// A request (req_valid/req_ready) carries an opcode, a VM slot and a level.
// Insert appends the slot at the tail of its level, remove unlinks it from
// anywhere in its level, and query changes nothing. Every request yields one
// response (rsp_valid/rsp_ready) with a status and the head of the highest
// non-empty level. The front end classifies requests into a two-entry queue,
// so requests keep being taken while the back end works or the response
// waits. The back end reads the list neighbors, then writes the links, then
// encodes the bitmap into the response register; it takes the next request
// from the queue only after the response of the last one is registered.
// When the receiver stalls, the response holds and the back end waits; the
// front queue then fills and req_ready drops. Reset empties every level and
// the queued flags; the link stores are not cleared since they are only
// read where valid.
// ----------------------------------------------------------------------------
module priority_ready_queue import prq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_vm_id,
   input  logic [4:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_any_ready,
   output logic [3:0]  rsp_top_vm,
   output logic [4:0]  rsp_top_priority
);

   // Work queue between the front and back ends.
   logic     wq_valid;
   logic     wq_pop;
   work_type wq_data;

   prq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_vm_id        (req_vm_id),
      .req_priority_req (req_priority_req),
      .wq_valid         (wq_valid),
      .wq_pop           (wq_pop),
      .wq_data          (wq_data)
   );

   prq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .wq_valid         (wq_valid),
      .wq_pop           (wq_pop),
      .wq_data          (wq_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_any_ready    (rsp_any_ready),
      .rsp_top_vm       (rsp_top_vm),
      .rsp_top_priority (rsp_top_priority)
   );

endmodule

// File: design/prq_front.sv
// ----------------------------------------------------------------------------
// prq_front
// Accepts requests, saturates the level and queues the decoded command.
// ----------------------------------------------------------------------------
module prq_front import prq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [3:0]        req_vm_id,
   input  logic [4:0]        req_priority_req,
   output logic              wq_valid,
   input  logic              wq_pop,
   output work_type          wq_data
);

   work_type         fifo_ff [QDEPTH];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   work_type         item;
   logic             push;

   always_comb begin
      item.vm  = VM_W'(req_vm_id);
      item.lvl = (32'(req_priority_req) >= PRIO_LEVELS) ? LVL_W'(PRIO_LEVELS - 1)
                                                         : LVL_W'(req_priority_req);
      unique case (opcode_type'(req_opcode))
         OP_INSERT: item.cmd = CMD_INSERT;
         OP_REMOVE: item.cmd = CMD_REMOVE;
         default:   item.cmd = CMD_NONE;
      endcase
      if (32'(req_vm_id) >= VM_SLOTS) item.cmd = CMD_NONE;
   end

   assign req_ready = (cnt_ff != 2'(QDEPTH));
   assign push      = req_valid && req_ready;
   assign wq_valid  = (cnt_ff != 2'd0);
   assign wq_data   = fifo_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = wq_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(wq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) fifo_ff[wp_ff] <= item;
   end

endmodule

// File: design/prq_back.sv
// ----------------------------------------------------------------------------
// prq_back
// Linked-list update of the level queues and highest-level report.
// ----------------------------------------------------------------------------
module prq_back import prq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wq_valid,
   output logic              wq_pop,
   input  work_type          wq_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_any_ready,
   output logic [3:0]        rsp_top_vm,
   output logic [4:0]        rsp_top_priority
);

   logic [PRIO_LEVELS-1:0] bitmap_ff, bitmap_in;
   logic [VM_SLOTS-1:0]    queued_ff, queued_in;
   logic [VM_W-1:0]        head_ff [PRIO_LEVELS];
   logic [VM_W-1:0]        tail_ff [PRIO_LEVELS];
   logic [VM_W-1:0]        next_ff [VM_SLOTS];
   logic [VM_W-1:0]        prev_ff [VM_SLOTS];
   logic [LVL_W-1:0]       sprio_ff [VM_SLOTS];

   back_state_type         state_ff, state_in;
   work_type               cur_ff;
   // Snapshot of neighbors taken in the read cycle.
   logic [LVL_W-1:0]       lvl_ff;
   logic [VM_W-1:0]        nx_ff, pv_ff, hd_ff, tl_ff;
   logic                   busy_ff;
   logic [1:0]             status_ff, status_in;
   logic                   out_valid_ff;
   logic                   any_ff;
   logic [VM_W-1:0]        top_vm_ff;
   logic [LVL_W-1:0]       top_lvl_ff;

   logic                   any_c;
   logic [LVL_W-1:0]       top_lvl_c;
   logic                   out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (wq_valid) state_in = BK_READ;
         BK_READ:  state_in = BK_WRITE;
         BK_WRITE: state_in = BK_OUT;
         BK_OUT:   if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      wq_pop = (state_ff == BK_IDLE) && wq_valid;
   end

   // Priority encode of the bitmap, highest set level wins.
   always_comb begin
      any_c     = |bitmap_ff;
      top_lvl_c = '0;
      for (int i = 0; i < PRIO_LEVELS; i++) begin
         if (bitmap_ff[i]) top_lvl_c = LVL_W'(i);
      end
   end

   always_comb begin
      status_in = ST_OK;
      if (cur_ff.cmd == CMD_INSERT && queued_ff[cur_ff.vm]) status_in = ST_DUP_INSERT;
      if (cur_ff.cmd == CMD_REMOVE && !queued_ff[cur_ff.vm]) status_in = ST_NOT_QUEUED;
   end

   always_comb begin
      bitmap_in = bitmap_ff;
      queued_in = queued_ff;
      if (state_ff == BK_WRITE && status_ff == ST_OK) begin
         if (cur_ff.cmd == CMD_INSERT) begin
            bitmap_in[cur_ff.lvl] = 1'b1;
            queued_in[cur_ff.vm]  = 1'b1;
         end else if (cur_ff.cmd == CMD_REMOVE) begin
            if (hd_ff == cur_ff.vm && tl_ff == cur_ff.vm) bitmap_in[lvl_ff] = 1'b0;
            queued_in[cur_ff.vm] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         bitmap_ff    <= '0;
         queued_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bitmap_ff <= bitmap_in;
         queued_ff <= queued_in;
         if (state_ff == BK_OUT && out_free) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end

      if (wq_pop) cur_ff <= wq_data;

      if (state_ff == BK_READ) begin
         status_ff <= status_in;
         lvl_ff    <= (cur_ff.cmd == CMD_INSERT) ? cur_ff.lvl : sprio_ff[cur_ff.vm];
         busy_ff   <= bitmap_ff[cur_ff.lvl];
         nx_ff     <= next_ff[cur_ff.vm];
         pv_ff     <= prev_ff[cur_ff.vm];
         hd_ff     <= head_ff[sprio_ff[cur_ff.vm]];
         tl_ff     <= (cur_ff.cmd == CMD_INSERT) ? tail_ff[cur_ff.lvl]
                                                 : tail_ff[sprio_ff[cur_ff.vm]];
      end

      if (state_ff == BK_WRITE && status_ff == ST_OK) begin
         if (cur_ff.cmd == CMD_INSERT) begin
            if (busy_ff) begin
               next_ff[tl_ff]     <= cur_ff.vm;
               prev_ff[cur_ff.vm] <= tl_ff;
            end else begin
               head_ff[lvl_ff] <= cur_ff.vm;
            end
            tail_ff[lvl_ff]     <= cur_ff.vm;
            sprio_ff[cur_ff.vm] <= lvl_ff;
         end else if (cur_ff.cmd == CMD_REMOVE) begin
            if (!(hd_ff == cur_ff.vm && tl_ff == cur_ff.vm)) begin
               if (hd_ff == cur_ff.vm) head_ff[lvl_ff] <= nx_ff;
               else                    next_ff[pv_ff]  <= nx_ff;
               if (tl_ff == cur_ff.vm) tail_ff[lvl_ff] <= pv_ff;
               else                    prev_ff[nx_ff]  <= pv_ff;
            end
         end
      end

      if (state_ff == BK_OUT && out_free) begin
         rsp_status   <= status_ff;
         any_ff       <= any_c;
         top_vm_ff    <= any_c ? head_ff[top_lvl_c] : '0;
         top_lvl_ff   <= top_lvl_c;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_any_ready    = any_ff;
   assign rsp_top_vm       = 4'(top_vm_ff);
   assign rsp_top_priority = 5'(top_lvl_ff);

endmodule

// File: tb/priority_ready_queue_checker.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_checker
// Watches both channels, predicts each response from its own copy of the
// run queue and compares every field against the oldest prediction.
// ----------------------------------------------------------------------------
module priority_ready_queue_checker import prq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_vm_id,
   input  logic [4:0]  req_priority_req,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_any_ready,
   input  logic [3:0]  rsp_top_vm,
   input  logic [4:0]  rsp_top_priority,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] status;
      logic       any_ready;
      logic [3:0] top_vm;
      logic [4:0] top_priority;
   } sched_view_type;

   logic [PRIO_LEVELS-1:0] busy_levels;
   logic [VM_W-1:0]        head_of [PRIO_LEVELS];
   logic [VM_W-1:0]        tail_of [PRIO_LEVELS];
   logic [VM_W-1:0]        succ_of [VM_SLOTS];
   logic [VM_W-1:0]        pred_of [VM_SLOTS];
   logic [VM_SLOTS-1:0]    on_queue;
   logic [LVL_W-1:0]       level_of [VM_SLOTS];
   sched_view_type         expected_views [$];

   assign pending_count = expected_views.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Applies one request to the shadow queue and returns the response it yields.
   function automatic sched_view_type schedule_step(logic [1:0] op, logic [3:0] vm,
                                                    logic [4:0] lvl);
      sched_view_type v;
      logic [VM_W-1:0] nx, pv;
      logic [LVL_W-1:0] l;
      bit hd, tl;
      v = '0;
      if (op == OP_INSERT) begin
         if (on_queue[vm]) begin
            v.status = ST_DUP_INSERT;
         end else begin
            if (busy_levels[lvl]) begin
               succ_of[tail_of[lvl]] = vm;
               pred_of[vm] = tail_of[lvl];
            end else begin
               head_of[lvl] = vm;
               busy_levels[lvl] = 1'b1;
            end
            tail_of[lvl] = vm;
            level_of[vm] = lvl;
            on_queue[vm] = 1'b1;
         end
      end else if (op == OP_REMOVE) begin
         if (!on_queue[vm]) begin
            v.status = ST_NOT_QUEUED;
         end else begin
            l = level_of[vm];
            nx = succ_of[vm];
            pv = pred_of[vm];
            hd = head_of[l] == vm;
            tl = tail_of[l] == vm;
            if (hd && tl) begin
               busy_levels[l] = 1'b0;
            end else begin
               if (hd) head_of[l] = nx;
               else succ_of[pv] = nx;
               if (tl) tail_of[l] = pv;
               else pred_of[nx] = pv;
            end
            on_queue[vm] = 1'b0;
         end
      end
      for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
         if (busy_levels[i]) begin
            v.any_ready = 1'b1;
            v.top_vm = head_of[i];
            v.top_priority = 5'(i);
            break;
         end
      end
      return v;
   endfunction

   always @(posedge clock) begin
      sched_view_type w;
      if (reset) begin
         busy_levels = '0;
         on_queue = '0;
         expected_views.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               w = expected_views.pop_front();
               if (rsp_status !== w.status)
                  report_mismatch("status", rsp_status, w.status);
               if (rsp_any_ready !== w.any_ready)
                  report_mismatch("any_ready", rsp_any_ready, w.any_ready);
               if (rsp_top_vm !== w.top_vm)
                  report_mismatch("top_vm", rsp_top_vm, w.top_vm);
               if (rsp_top_priority !== w.top_priority)
                  report_mismatch("top_priority", rsp_top_priority, w.top_priority);
            end
         end
         if (req_valid && req_ready)
            expected_views.push_back(schedule_step(req_opcode, req_vm_id,
                                                   req_priority_req));
      end
   end

   initial fail_count = 0;
endmodule

// File: tb/priority_ready_queue_tb.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_tb
// Drives directed and random run-queue requests with random gaps and
// response stalls; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module priority_ready_queue_tb;
   import prq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = OP_QUERY;
   logic [3:0] req_vm_id = '0;
   logic [4:0] req_priority_req = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_any_ready;
   logic [3:0] rsp_top_vm;
   logic [4:0] rsp_top_priority;
   int         fail_count;
   int         pending_count;
   bit         requests_done = 1'b0;

   always #5 clock = ~clock;

   priority_ready_queue u_dut (.*);

   priority_ready_queue_checker u_checker (.*);

   // Sends one request after a random gap and holds it until it is taken.
   // Valid stays high after the accepting edge; a gap or the caller drops it.
   task automatic send_request(input logic [1:0] op, input logic [3:0] vm,
                               input logic [4:0] lvl);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_vm_id <= vm;
      req_priority_req <= lvl;
      do @(posedge clock); while (!req_ready);
   endtask

   // The receiver draws a stall length for every response it takes.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [1:0] op;
      logic [3:0] vm;
      logic [4:0] lvl;
      int         pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty query and removal, the lowest and highest levels,
      // FIFO order within one level, duplicate insert, and unlinking a slot from
      // the head, the middle and the tail of a level.
      send_request(OP_QUERY, 4'd0, 5'd0);
      send_request(OP_REMOVE, 4'd3, 5'd0);
      send_request(OP_INSERT, 4'd0, 5'd0);
      send_request(OP_INSERT, 4'd15, 5'd31);
      send_request(OP_INSERT, 4'd15, 5'd2);
      send_request(OP_INSERT, 4'd5, 5'd31);
      send_request(OP_INSERT, 4'd6, 5'd31);
      send_request(OP_INSERT, 4'd7, 5'd31);
      send_request(OP_REMOVE, 4'd6, 5'd0);
      send_request(OP_REMOVE, 4'd15, 5'd0);
      send_request(OP_REMOVE, 4'd7, 5'd0);
      send_request(OP_SPARE, 4'd9, 5'd17);
      send_request(OP_REMOVE, 4'd5, 5'd0);
      send_request(OP_REMOVE, 4'd5, 5'd0);
      send_request(OP_REMOVE, 4'd0, 5'd0);
      send_request(OP_QUERY, 4'd15, 5'd31);
      req_valid <= 1'b0;
      @(posedge clock);

      // The sender holds off until every response is back.
      while (pending_count != 0) @(posedge clock);

      // Random part: mostly inserts and removes over a few levels so lists grow
      // long, with the whole level range and spare opcodes mixed in.
      for (int n = 0; n < 1200; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) op = OP_INSERT;
         else if (pick < 8) op = OP_REMOVE;
         else if (pick == 8) op = OP_QUERY;
         else op = OP_SPARE;
         vm = 4'($urandom);
         lvl = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(28, 31));
         send_request(op, vm, lvl);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("PASS priority_ready_queue");
      else
         $display("FAIL priority_ready_queue");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL priority_ready_queue");
      $finish;
   end
endmodule

// File: sim.f
design/prq_pkg.sv
design/prq_front.sv
design/prq_back.sv
design/priority_ready_queue.sv
tb/priority_ready_queue_checker.sv
tb/priority_ready_queue_tb.sv
